### rtl/bcg_pkg.sv
// ----------------------------------------------------------------------------
// bcg_pkg
// Shared types and constants of the circle rasterizer.
// ----------------------------------------------------------------------------
package bcg_pkg;

   // default field widths
   localparam int RADIUS_BITS_DEF = 10;
   localparam int COORD_BITS_DEF  = 12;

   // extra bits of the decision value beyond the radius width
   localparam int DEC_EXTRA = 4;

   // decision value constants
   localparam int DEC_INIT    = 3;
   localparam int DEC_NEG_INC = 6;
   localparam int DEC_POS_INC = 10;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // item function codes
   typedef enum logic [0:0] {
      FUNC_START = 1'b0,
      FUNC_STEP  = 1'b1
   } func_type;

   // symmetric point slots of one group, in output order
   typedef enum logic [2:0] {
      SLOT_0 = 3'd0,
      SLOT_1 = 3'd1,
      SLOT_2 = 3'd2,
      SLOT_3 = 3'd3,
      SLOT_4 = 3'd4,
      SLOT_5 = 3'd5,
      SLOT_6 = 3'd6,
      SLOT_7 = 3'd7
   } slot_type;

   // queue handshake between front, queue and back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/bcg_queue.sv
// ----------------------------------------------------------------------------
// bcg_queue
// Short register queue carrying point groups from front to back.
// ----------------------------------------------------------------------------
module bcg_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = bcg_pkg::QUEUE_DEPTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output logic [WIDTH-1:0]         pop_data,
   output bcg_pkg::queue_status_type status
);
   import bcg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

### rtl/bcg_front.sv
// ----------------------------------------------------------------------------
// bcg_front
// Accepts items, runs the decision variable and queues one point group
// per start or active step.
// ----------------------------------------------------------------------------
module bcg_front #(
   parameter int RADIUS_BITS = bcg_pkg::RADIUS_BITS_DEF,
   parameter int COORD_BITS  = bcg_pkg::COORD_BITS_DEF,
   parameter int GRP_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic signed [COORD_BITS-1:0]  req_center_x,
   input  logic signed [COORD_BITS-1:0]  req_center_y,
   input  logic [RADIUS_BITS-1:0]        req_radius,
   output logic                          push,
   output logic [GRP_W-1:0]              push_data,
   input  bcg_pkg::queue_status_type     status
);
   import bcg_pkg::*;

   localparam int DW = RADIUS_BITS + DEC_EXTRA;

   logic                         active_ff, active_in;
   logic [RADIUS_BITS-1:0]       x_ff, x_in;
   logic [RADIUS_BITS-1:0]       y_ff, y_in;
   logic [DW-1:0]                p_ff, p_in;
   logic signed [COORD_BITS-1:0] cx_ff, cx_in;
   logic signed [COORD_BITS-1:0] cy_ff, cy_in;
   logic                         accept;
   logic                         done;

   assign req_stall = status.full;
   assign accept    = req_valid && !req_stall;

   // decision update and group generation
   always_comb begin
      active_in = active_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      p_in      = p_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      push      = 1'b0;
      if (accept) begin
         if (req_func == FUNC_START) begin
            cx_in = req_center_x;
            cy_in = req_center_y;
            x_in  = '0;
            y_in  = req_radius;
            p_in  = DW'(DEC_INIT) - (DW'(req_radius) << 1);
            push  = 1'b1;
         end else if (active_ff) begin
            if (p_ff[DW-1]) begin
               p_in = p_ff + (DW'(x_ff) << 2) + DW'(DEC_NEG_INC);
            end else begin
               p_in = p_ff + (DW'(x_ff) << 2) - (DW'(y_ff) << 2) + DW'(DEC_POS_INC);
               y_in = y_ff - 1'b1;
            end
            x_in = x_ff + 1'b1;
            push = 1'b1;
         end
      end
      done = !(x_in < y_in);
      if (push) begin
         active_in = !done;
      end
      push_data = {cx_in, cy_in, x_in, y_in, done};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         x_ff      <= '0;
         y_ff      <= '0;
         p_ff      <= '0;
         cx_ff     <= '0;
         cy_ff     <= '0;
      end else begin
         active_ff <= active_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
         p_ff      <= p_in;
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
      end
   end

endmodule

### rtl/bcg_back.sv
// ----------------------------------------------------------------------------
// bcg_back
// Takes point groups from the queue and sends the eight mirrored points
// one per cycle through the output register while rsp_stall does not hold it.
// ----------------------------------------------------------------------------
module bcg_back #(
   parameter int RADIUS_BITS = bcg_pkg::RADIUS_BITS_DEF,
   parameter int COORD_BITS  = bcg_pkg::COORD_BITS_DEF,
   parameter int GRP_W       = 2 * COORD_BITS + 2 * RADIUS_BITS + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [GRP_W-1:0]              pop_data,
   output logic                          pop,
   input  bcg_pkg::queue_status_type     status,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS:0]    rsp_point_x,
   output logic signed [COORD_BITS:0]    rsp_point_y,
   output logic                          rsp_last_point
);
   import bcg_pkg::*;

   localparam int OW = COORD_BITS + 1;

   // current group
   logic                         grp_valid_ff, grp_valid_in;
   slot_type                     slot_ff, slot_in;
   logic signed [COORD_BITS-1:0] cx_ff, cx_in;
   logic signed [COORD_BITS-1:0] cy_ff, cy_in;
   logic [RADIUS_BITS-1:0]       x_ff, x_in;
   logic [RADIUS_BITS-1:0]       y_ff, y_in;
   logic                         done_ff, done_in;

   // output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [OW-1:0]         px_ff, px_in;
   logic signed [OW-1:0]         py_ff, py_in;
   logic                         last_ff, last_in;

   logic                         load_out;
   logic                         end_grp;
   logic signed [OW-1:0]         wcx, wcy, wx, wy;

   assign load_out = grp_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign end_grp  = load_out && (slot_ff == SLOT_7);
   assign pop      = !status.empty && (!grp_valid_ff || end_grp);

   // group sequencing
   always_comb begin
      grp_valid_in = grp_valid_ff;
      slot_in      = slot_ff;
      {cx_in, cy_in, x_in, y_in, done_in} = {cx_ff, cy_ff, x_ff, y_ff, done_ff};
      if (pop) begin
         grp_valid_in = 1'b1;
         slot_in      = SLOT_0;
         {cx_in, cy_in, x_in, y_in, done_in} = pop_data;
      end else if (end_grp) begin
         grp_valid_in = 1'b0;
      end else if (load_out) begin
         slot_in = slot_type'(slot_ff + 3'd1);
      end
   end

   // mirrored point of the current slot
   always_comb begin
      wcx = OW'(cx_ff);
      wcy = OW'(cy_ff);
      wx  = OW'(x_ff);
      wy  = OW'(y_ff);
      unique case (slot_ff)
         SLOT_0: begin px_in = wcx + wx; py_in = wcy + wy; end
         SLOT_1: begin px_in = wcx + wy; py_in = wcy + wx; end
         SLOT_2: begin px_in = wcx + wy; py_in = wcy - wx; end
         SLOT_3: begin px_in = wcx + wx; py_in = wcy - wy; end
         SLOT_4: begin px_in = wcx - wx; py_in = wcy - wy; end
         SLOT_5: begin px_in = wcx - wy; py_in = wcy - wx; end
         SLOT_6: begin px_in = wcx - wy; py_in = wcy + wx; end
         SLOT_7: begin px_in = wcx - wx; py_in = wcy + wy; end
         default: begin px_in = wcx; py_in = wcy; end
      endcase
      last_in = done_ff && (slot_ff == SLOT_7);
   end

   // output valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_valid_ff <= 1'b0;
         slot_ff      <= SLOT_0;
         rsp_valid_ff <= 1'b0;
      end else begin
         grp_valid_ff <= grp_valid_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      done_ff <= done_in;
      if (load_out) begin
         px_ff   <= px_in;
         py_ff   <= py_in;
         last_ff <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = px_ff;
   assign rsp_point_y    = py_ff;
   assign rsp_last_point = last_ff;

endmodule

### rtl/bresenham_circle_generator.sv
// Circle rasterizer with eightfold symmetry. A start item (func 0) loads
// centre and radius and yields eight points; each step item (func 1) of an
// active circle moves one pixel along the octant and yields eight more, the
// last of the circle flagged by rsp_last_point. A step while idle is taken
// and yields nothing. Each item with results occupies the point sender for
// its eight points, one point per cycle while rsp_stall does not hold them;
// the first point passes through the group queue, the current-group
// registers and the output register before it shows on rsp_valid. A
// two-entry group queue sits between the decision logic and the sender, so
// up to two further items are taken while points are still going out.
// ----------------------------------------------------------------------------
// bresenham_circle_generator
// Top level: decision front, group queue and point sender.
// ----------------------------------------------------------------------------
module bresenham_circle_generator #(
   parameter int RADIUS_BITS = bcg_pkg::RADIUS_BITS_DEF,
   parameter int COORD_BITS  = bcg_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic signed [COORD_BITS-1:0]  req_center_x,
   input  logic signed [COORD_BITS-1:0]  req_center_y,
   input  logic [RADIUS_BITS-1:0]        req_radius,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [COORD_BITS:0]    rsp_point_x,
   output logic signed [COORD_BITS:0]    rsp_point_y,
   output logic                          rsp_last_point
);
   import bcg_pkg::*;

   localparam int GRP_W = 2 * COORD_BITS + 2 * RADIUS_BITS + 1;

   logic             push;
   logic [GRP_W-1:0] push_data;
   logic             pop;
   logic [GRP_W-1:0] pop_data;
   queue_status_type status;

   // decision front
   bcg_front #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS),
      .GRP_W       (GRP_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_radius   (req_radius),
      .push         (push),
      .push_data    (push_data),
      .status       (status)
   );

   // group queue
   bcg_queue #(
      .WIDTH (GRP_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   // point sender
   bcg_back #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS),
      .GRP_W       (GRP_W)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_data       (pop_data),
      .pop            (pop),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_last_point (rsp_last_point)
   );

endmodule

### rtl/bcg_checker.sv
// ----------------------------------------------------------------------------
// bcg_checker
// Port-level checks of the circle rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module bcg_checker #(
   parameter int COORD_BITS  = bcg_pkg::COORD_BITS_DEF
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic signed [COORD_BITS:0]    rsp_point_x,
   input logic signed [COORD_BITS:0]    rsp_point_y,
   input logic                          rsp_last_point
);

   // stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // stalled result payload holds
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_point_x) && $stable(rsp_point_y)
         && $stable(rsp_last_point))
      else $error("result payload changed while stalled");

   // no result straight out of reset
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // empty queue after reset takes items
   a_req_reset: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled after reset");

endmodule

bind bresenham_circle_generator bcg_checker #(
   .COORD_BITS  (COORD_BITS)
) u_bcg_checker (.*);
